// File: src/rhsi_pkg.sv
// shared types and constants for the rgb to hsi pixel converter
package rhsi_pkg;

  // input pixel word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  // result word
  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [6:0] saturation_percent;
    logic [7:0] intensity;
  } pixel_out_t;

  // default fraction width of the angle datapath
  localparam int FRACTION_BITS_DEF = 16;

  // number of taylor terms in the arctangent series
  localparam int SERIES_TERMS = 16;

  // q32 constants, shifted down to the working fraction width
  localparam logic [63:0] PI_Q32          = 64'h0000_0003_243F_6A88;
  localparam logic [63:0] SQRT3_Q32       = 64'h0000_0001_BB67_AE85;
  localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499207;

  // reciprocal of three for the intensity mean
  localparam logic [10:0] THIRD_RECIP = 11'd1366;
  localparam int          THIRD_SHIFT = 12;

  // saturation quotient width
  localparam int SAT_QW = 7;

  // fixed first-quadrant angle codes
  localparam int         SPEC_W     = 3;
  localparam logic [2:0] FIRST_CALC = 3'd0;
  localparam logic [2:0] FIRST_0    = 3'd1;
  localparam logic [2:0] FIRST_30   = 3'd2;
  localparam logic [2:0] FIRST_60   = 3'd3;
  localparam logic [2:0] FIRST_90   = 3'd4;

  // per-pixel side information that rides along the pipeline
  typedef struct packed {
    logic              swap;
    logic [SPEC_W-1:0] spec;
    logic              bgtg;
    logic              xneg;
    logic              sum0;
    logic [7:0]        intensity;
  } hsi_flags_t;

endpackage

// File: src/rgb_to_hsi_pixel_converter.sv
// rgb to hsi pixel converter top level
//
// Converts one 8-bit rgb pixel per word into hue in whole degrees,
// saturation in whole percent and intensity (mean of the channels).
// Input channel: in_valid / in_ready / in_data (pixel_in_t).
// Result channel: out_valid / out_ready / out_data (pixel_out_t).
// One result word leaves for every pixel word taken, in order.
// Throughput: one pixel per clock while in_ready is high; pixels are independent.
// From accept to out_valid the word passes a row of cells: two input
// stages, a 7-cell saturation divider, two FRACTION_BITS+1 cell angle
// dividers with the reflection stage p2 between them, the series
// argument stage p3, 16 two-stage arctangent series cells, the angle
// to hue stages p4 to p6 and the output register.
// Stall: a skid register behind the output register lets the block
// keep taking pixels while one result waits; when both hold words the
// whole row freezes and in_ready drops until out_ready returns.
// Reset: rst_n (synchronous, active low) empties all stages; no
// word in flight survives reset.
module rgb_to_hsi_pixel_converter
  import rhsi_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pixel_out_t out_data
);

  localparam int F   = FRACTION_BITS;
  localparam int DW1 = F + 9;
  localparam int DW2 = F + 2;
  localparam int NQ  = F + 1;

  localparam logic [F:0]   SQRT3_FX      = (F+1)'(SQRT3_Q32 >> (32 - F));
  localparam logic [F+5:0] DEG_FX        = (F+6)'(DEG_PER_RAD_Q32 >> (32 - F));
  localparam logic [F:0]   HALF_PI_FX    = (F+1)'(PI_Q32 >> (33 - F));
  localparam logic [F:0]   QUARTER_PI_FX = (F+1)'(PI_Q32 >> (34 - F));
  localparam logic [F+6:0] DEG30_FX      = (F+7)'(30) << F;
  localparam logic [F+6:0] DEG60_FX      = (F+7)'(60) << F;
  localparam logic [F+6:0] DEG90_FX      = (F+7)'(90) << F;
  localparam logic [F+7:0] DEG180_FX     = (F+8)'(180) << F;
  localparam logic [F+8:0] DEG360_FX     = (F+9)'(360) << F;
  localparam logic [NQ-1:0] HALF_ONE     = NQ'(1) << (F - 1);
  localparam logic [DW2-1:0] ONE_FX      = DW2'(1) << F;

  // side data carried by each section of the row
  typedef struct packed {
    logic [DW1-1:0] num1;
    logic [DW1-1:0] den1;
    hsi_flags_t     flags;
  } sat_ctx_t;

  typedef struct packed {
    logic [SAT_QW-1:0] sat;
    hsi_flags_t        flags;
  } res_ctx_t;

  typedef struct packed {
    logic [NQ-1:0] t;
    logic          reflect;
    res_ctx_t      res;
  } div2_ctx_t;

  typedef struct packed {
    logic     reflect;
    res_ctx_t res;
  } ser_ctx_t;

  localparam int SAT_CW  = $bits(sat_ctx_t);
  localparam int RES_CW  = $bits(res_ctx_t);
  localparam int DIV2_CW = $bits(div2_ctx_t);
  localparam int SER_CW  = $bits(ser_ctx_t);

  logic en;

  // ---------------------------------------------------------------
  // stage 0: channel differences, sum, minimum, scaled green-blue gap
  logic signed [10:0] x_nxt;
  logic [8:0]         a_nxt;
  logic [7:0]         d_nxt;
  logic [9:0]         sum_nxt;
  logic [7:0]         mn_rg;
  logic [7:0]         mn_nxt;
  logic [DW1-1:0]     bf_nxt;

  assign x_nxt = $signed({2'b0, in_data.red, 1'b0}) - $signed({3'b0, in_data.green})
                 - $signed({3'b0, in_data.blue});
  assign a_nxt = x_nxt[10] ? 9'(-x_nxt) : x_nxt[8:0];
  assign d_nxt = (in_data.green > in_data.blue) ? (in_data.green - in_data.blue)
                                                : (in_data.blue - in_data.green);
  assign sum_nxt = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
  assign mn_rg   = (in_data.red < in_data.green) ? in_data.red : in_data.green;
  assign mn_nxt  = (in_data.blue < mn_rg) ? in_data.blue : mn_rg;
  assign bf_nxt  = DW1'(d_nxt) * DW1'(SQRT3_FX);

  logic           s0_vld_r;
  logic [8:0]     s0_a_r;
  logic [7:0]     s0_d_r;
  logic [9:0]     s0_sum_r;
  logic [7:0]     s0_mn_r;
  logic [DW1-1:0] s0_bf_r;
  logic           s0_bgtg_r;
  logic           s0_xneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a_r    <= a_nxt;
      s0_d_r    <= d_nxt;
      s0_sum_r  <= sum_nxt;
      s0_mn_r   <= mn_nxt;
      s0_bf_r   <= bf_nxt;
      s0_bgtg_r <= in_data.blue > in_data.green;
      s0_xneg_r <= x_nxt[10];
    end
  end

  // ---------------------------------------------------------------
  // stage 1: octant swap, fixed angles, saturation dividend, intensity
  logic [DW1-1:0]    af;
  logic              swap;
  logic [SPEC_W-1:0] spec;
  logic [9:0]        sat_diff;
  logic [16:0]       satnum;
  logic [20:0]       inten_prod;
  hsi_flags_t        flags_nxt;

  assign af   = {s0_a_r, F'(0)};
  assign swap = s0_bf_r > af;

  always_comb begin
    if (s0_d_r == 8'd0) begin
      spec = (s0_a_r == 9'd0) ? FIRST_90 : FIRST_0;
    end else if (s0_a_r == 9'd0) begin
      spec = FIRST_90;
    end else if (10'(s0_a_r) == 10'(s0_d_r) * 10'd3) begin
      spec = FIRST_30;
    end else if (s0_a_r == 9'(s0_d_r)) begin
      spec = FIRST_60;
    end else begin
      spec = FIRST_CALC;
    end
  end

  assign sat_diff   = s0_sum_r - 10'(s0_mn_r) * 10'd3;
  assign satnum     = 17'(sat_diff) * 17'd100;
  assign inten_prod = 21'(s0_sum_r) * 21'(THIRD_RECIP);

  assign flags_nxt.swap      = swap;
  assign flags_nxt.spec      = spec;
  assign flags_nxt.bgtg      = s0_bgtg_r;
  assign flags_nxt.xneg      = s0_xneg_r;
  assign flags_nxt.sum0      = s0_sum_r == 10'd0;
  assign flags_nxt.intensity = inten_prod[THIRD_SHIFT +: 8];

  logic           s1_vld_r;
  logic [9:0]     s1_rem0_r;
  logic [6:0]     s1_bits_r;
  logic [9:0]     s1_den_r;
  sat_ctx_t       s1_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rem0_r      <= satnum[16:7];
      s1_bits_r      <= satnum[6:0];
      s1_den_r       <= s0_sum_r;
      s1_ctx_r.num1  <= swap ? af : s0_bf_r;
      s1_ctx_r.den1  <= swap ? s0_bf_r : af;
      s1_ctx_r.flags <= flags_nxt;
    end
  end

  // ---------------------------------------------------------------
  // saturation divider row
  logic              sd_vld;
  logic [SAT_QW-1:0] sd_quot;
  logic [SAT_CW-1:0] sd_ctx_vec;
  sat_ctx_t          sd_ctx;

  rhsi_div_chain #(
    .RW(10),
    .NC(SAT_QW),
    .CW(SAT_CW)
  ) u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (s1_vld_r),
    .rem_in  (s1_rem0_r),
    .den_in  (s1_den_r),
    .bits_in (s1_bits_r),
    .ctx_in  (s1_ctx_r),
    .vld_out (sd_vld),
    .quot_out(sd_quot),
    .ctx_out (sd_ctx_vec)
  );

  assign sd_ctx = sd_ctx_vec;

  // ---------------------------------------------------------------
  // ratio divider row: t = min * 2^F / max
  res_ctx_t          d1_ctx_in;
  logic              d1_vld;
  logic [NQ-1:0]     d1_t;
  logic [RES_CW-1:0] d1_ctx_vec;
  res_ctx_t          d1_ctx;

  assign d1_ctx_in.sat   = sd_quot;
  assign d1_ctx_in.flags = sd_ctx.flags;

  rhsi_div_chain #(
    .RW(DW1),
    .NC(NQ),
    .CW(RES_CW)
  ) u_ratio_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (sd_vld),
    .rem_in  (sd_ctx.num1 >> 1),
    .den_in  (sd_ctx.den1),
    .bits_in ({sd_ctx.num1[0], F'(0)}),
    .ctx_in  (d1_ctx_in),
    .vld_out (d1_vld),
    .quot_out(d1_t),
    .ctx_out (d1_ctx_vec)
  );

  assign d1_ctx = d1_ctx_vec;

  // ---------------------------------------------------------------
  // stage p2: reflection about one half
  logic           reflect;
  logic [DW2-1:0] num2;
  logic [DW2-1:0] den2;

  assign reflect = d1_t > HALF_ONE;
  assign num2    = ONE_FX - DW2'(d1_t);
  assign den2    = ONE_FX + DW2'(d1_t);

  logic           p2_vld_r;
  logic [DW2-1:0] p2_rem0_r;
  logic [NQ-1:0]  p2_bits_r;
  logic [DW2-1:0] p2_den_r;
  div2_ctx_t      p2_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_rem0_r        <= num2 >> 1;
      p2_bits_r        <= {num2[0], F'(0)};
      p2_den_r         <= den2;
      p2_ctx_r.t       <= d1_t;
      p2_ctx_r.reflect <= reflect;
      p2_ctx_r.res     <= d1_ctx;
    end
  end

  // reflected ratio divider row: (1 - t) / (1 + t)
  logic               d2_vld;
  logic [NQ-1:0]      d2_q;
  logic [DIV2_CW-1:0] d2_ctx_vec;
  div2_ctx_t          d2_ctx;

  rhsi_div_chain #(
    .RW(DW2),
    .NC(NQ),
    .CW(DIV2_CW)
  ) u_refl_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (p2_vld_r),
    .rem_in  (p2_rem0_r),
    .den_in  (p2_den_r),
    .bits_in (p2_bits_r),
    .ctx_in  (p2_ctx_r),
    .vld_out (d2_vld),
    .quot_out(d2_q),
    .ctx_out (d2_ctx_vec)
  );

  assign d2_ctx = d2_ctx_vec;

  // ---------------------------------------------------------------
  // stage p3: series argument and its square
  logic [F-1:0]   v_sel;
  logic [2*F-1:0] vsq;

  assign v_sel = d2_ctx.reflect ? d2_q[F-1:0] : d2_ctx.t[F-1:0];
  assign vsq   = (2*F)'(v_sel) * (2*F)'(v_sel);

  logic     p3_vld_r;
  logic [F-1:0] p3_v_r;
  logic [F-2:0] p3_v2_r;
  ser_ctx_t p3_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_v_r           <= v_sel;
      p3_v2_r          <= vsq[2*F-2:F];
      p3_ctx_r.reflect <= d2_ctx.reflect;
      p3_ctx_r.res     <= d2_ctx.res;
    end
  end

  // ---------------------------------------------------------------
  // arctangent series row
  logic              sr_vld   [SERIES_TERMS+1];
  logic [F-1:0]      sr_power [SERIES_TERMS+1];
  logic [F-2:0]      sr_v2    [SERIES_TERMS+1];
  logic [F-1:0]      sr_sum   [SERIES_TERMS+1];
  logic [SER_CW-1:0] sr_ctx   [SERIES_TERMS+1];

  assign sr_vld[0]   = p3_vld_r;
  assign sr_power[0] = p3_v_r;
  assign sr_v2[0]    = p3_v2_r;
  assign sr_sum[0]   = '0;
  assign sr_ctx[0]   = p3_ctx_r;

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    rhsi_series_cell #(
      .FW(F),
      .K (k),
      .CW(SER_CW)
    ) u_term (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (sr_vld[k]),
      .power_in(sr_power[k]),
      .v2_in   (sr_v2[k]),
      .sum_in  (sr_sum[k]),
      .ctx_in  (sr_ctx[k]),
      .vld_r   (sr_vld[k+1]),
      .power_r (sr_power[k+1]),
      .v2_r    (sr_v2[k+1]),
      .sum_r   (sr_sum[k+1]),
      .ctx_r   (sr_ctx[k+1])
    );
  end

  ser_ctx_t sr_out_ctx;
  assign sr_out_ctx = sr_ctx[SERIES_TERMS];

  // ---------------------------------------------------------------
  // stage p4: undo reflection and octant swap, clamp at zero
  logic [F:0]          atn;
  logic signed [F+1:0] theta_s;

  assign atn     = sr_out_ctx.reflect ? (QUARTER_PI_FX - (F+1)'(sr_sum[SERIES_TERMS]))
                                      : (F+1)'(sr_sum[SERIES_TERMS]);
  assign theta_s = sr_out_ctx.res.flags.swap ? ($signed({1'b0, HALF_PI_FX})
                                                - $signed({1'b0, atn}))
                                             : $signed({1'b0, atn});

  logic     p4_vld_r;
  logic [F:0] p4_theta_r;
  res_ctx_t p4_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p4_vld_r <= sr_vld[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_theta_r <= theta_s[F+1] ? '0 : theta_s[F:0];
      p4_ctx_r   <= sr_out_ctx.res;
    end
  end

  // ---------------------------------------------------------------
  // stage p5: radians to degrees
  logic [2*F+6:0] deg_prod;

  assign deg_prod = (2*F+7)'(p4_theta_r) * (2*F+7)'(DEG_FX);

  logic     p5_vld_r;
  logic [F+6:0] p5_first_r;
  res_ctx_t p5_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else if (en) begin
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_first_r <= deg_prod[2*F+6:F];
      p5_ctx_r   <= p4_ctx_r;
    end
  end

  // ---------------------------------------------------------------
  // stage p6: fixed angles, supplement, hue side, saturation select
  logic [F+6:0] first;
  logic [F+7:0] deg;
  logic [F+8:0] hue_wide;
  logic [8:0]   hue_hi;
  logic [8:0]   hue_lo;
  pixel_out_t   p6_nxt;

  always_comb begin
    unique case (p5_ctx_r.flags.spec)
      FIRST_CALC: first = (p5_first_r > DEG90_FX) ? DEG90_FX : p5_first_r;
      FIRST_0:    first = '0;
      FIRST_30:   first = DEG30_FX;
      FIRST_60:   first = DEG60_FX;
      FIRST_90:   first = DEG90_FX;
      default:    first = DEG90_FX;
    endcase
  end

  assign deg      = p5_ctx_r.flags.xneg ? (DEG180_FX - (F+8)'(first)) : (F+8)'(first);
  assign hue_wide = DEG360_FX - (F+9)'(deg);
  assign hue_hi   = (hue_wide[F+8:F] > 9'd359) ? 9'd359 : hue_wide[F+8:F];
  assign hue_lo   = (deg[F+7:F] > 8'd180) ? 9'd180 : 9'(deg[F+7:F]);

  assign p6_nxt.hue_degrees        = p5_ctx_r.flags.bgtg ? hue_hi : hue_lo;
  assign p6_nxt.saturation_percent = p5_ctx_r.flags.sum0 ? 7'd100 : p5_ctx_r.sat;
  assign p6_nxt.intensity          = p5_ctx_r.flags.intensity;

  logic       p6_vld_r;
  pixel_out_t p6_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else if (en) begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_data_r <= p6_nxt;
    end
  end

  // ---------------------------------------------------------------
  // output register with skid stage
  logic       out_valid_r;
  logic       skid_valid_r;
  pixel_out_t out_data_r;
  pixel_out_t skid_data_r;
  logic       take;

  assign take     = out_valid_r && out_ready;
  assign en       = !skid_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (p6_vld_r) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (p6_vld_r) begin
      if (!out_valid_r || take) begin
        out_data_r <= p6_data_r;
      end else begin
        skid_data_r <= p6_data_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled while the output was free");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hue_degrees <= 9'd359
                     && out_data_r.saturation_percent <= 7'd100))
    else $error("result word out of range");
`endif

endmodule

// File: src/rhsi_div_cell.sv
// one restoring division step: shift in a dividend bit, compare, subtract
module rhsi_div_cell #(
  parameter int RW = 10,
  parameter int NC = 7,
  parameter int CW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] den_in,
  input  logic [NC-1:0] bits_in,
  input  logic [NC-1:0] quot_in,
  input  logic [CW-1:0] ctx_in,
  output logic          vld_r,
  output logic [RW-1:0] rem_r,
  output logic [RW-1:0] den_r,
  output logic [NC-1:0] bits_r,
  output logic [NC-1:0] quot_r,
  output logic [CW-1:0] ctx_r
);

  logic [RW:0] rem_s;
  logic [RW:0] diff;
  logic        ge;

  // trial subtract of the divisor
  assign rem_s = {rem_in, bits_in[NC-1]};
  assign diff  = rem_s - {1'b0, den_in};
  assign ge    = rem_s >= {1'b0, den_in};

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? diff[RW-1:0] : rem_s[RW-1:0];
      den_r  <= den_in;
      bits_r <= {bits_in[NC-2:0], 1'b0};
      quot_r <= {quot_in[NC-2:0], ge};
      ctx_r  <= ctx_in;
    end
  end

endmodule

// File: src/rhsi_div_chain.sv
// row of division cells, one quotient bit per cell
module rhsi_div_chain #(
  parameter int RW = 10,
  parameter int NC = 7,
  parameter int CW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] den_in,
  input  logic [NC-1:0] bits_in,
  input  logic [CW-1:0] ctx_in,
  output logic          vld_out,
  output logic [NC-1:0] quot_out,
  output logic [CW-1:0] ctx_out
);

  logic          vld_w  [NC+1];
  logic [RW-1:0] rem_w  [NC+1];
  logic [RW-1:0] den_w  [NC+1];
  logic [NC-1:0] bits_w [NC+1];
  logic [NC-1:0] quot_w [NC+1];
  logic [CW-1:0] ctx_w  [NC+1];

  // head of the row
  assign vld_w[0]  = vld_in;
  assign rem_w[0]  = rem_in;
  assign den_w[0]  = den_in;
  assign bits_w[0] = bits_in;
  assign quot_w[0] = '0;
  assign ctx_w[0]  = ctx_in;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rhsi_div_cell #(
      .RW(RW),
      .NC(NC),
      .CW(CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_in (vld_w[i]),
      .rem_in (rem_w[i]),
      .den_in (den_w[i]),
      .bits_in(bits_w[i]),
      .quot_in(quot_w[i]),
      .ctx_in (ctx_w[i]),
      .vld_r  (vld_w[i+1]),
      .rem_r  (rem_w[i+1]),
      .den_r  (den_w[i+1]),
      .bits_r (bits_w[i+1]),
      .quot_r (quot_w[i+1]),
      .ctx_r  (ctx_w[i+1])
    );
  end

  // tail of the row
  assign vld_out  = vld_w[NC];
  assign quot_out = quot_w[NC];
  assign ctx_out  = ctx_w[NC];

endmodule

// File: src/rhsi_series_cell.sv
// one arctangent series term: divide the power by its odd index, accumulate, next power
module rhsi_series_cell #(
  parameter int FW = 16,
  parameter int K  = 0,
  parameter int CW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  logic [FW-1:0] power_in,
  input  logic [FW-2:0] v2_in,
  input  logic [FW-1:0] sum_in,
  input  logic [CW-1:0] ctx_in,
  output logic          vld_r,
  output logic [FW-1:0] power_r,
  output logic [FW-2:0] v2_r,
  output logic [FW-1:0] sum_r,
  output logic [CW-1:0] ctx_r
);

  localparam int DIVISOR = 2 * K + 1;
  localparam int SH      = FW + 5;
  localparam int MW      = FW + 6;
  localparam int PTW     = FW + MW;
  localparam int PPW     = 2 * FW - 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam bit NEG = (K % 2) == 1;

  logic           vld_a_r;
  logic [PTW-1:0] pt_a_r;
  logic [PPW-1:0] pp_a_r;
  logic [FW-1:0]  sum_a_r;
  logic [FW-2:0]  v2_a_r;
  logic [CW-1:0]  ctx_a_r;

  logic [PTW-1:0] pt_nxt;
  logic [PPW-1:0] pp_nxt;
  logic [FW-1:0]  term;
  logic [FW-1:0]  sum_nxt;

  // reciprocal product for the term and product for the next power
  assign pt_nxt = PTW'(power_in) * PTW'(RECIP);
  assign pp_nxt = PPW'(power_in) * PPW'(v2_in);

  // term and running sum with alternating sign
  assign term    = pt_a_r[SH +: FW];
  assign sum_nxt = NEG ? (sum_a_r - term) : (sum_a_r + term);

  // valids of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
      vld_r   <= vld_a_r;
    end
  end

  // multiply stage then accumulate stage
  always_ff @(posedge clk) begin
    if (en) begin
      pt_a_r  <= pt_nxt;
      pp_a_r  <= pp_nxt;
      sum_a_r <= sum_in;
      v2_a_r  <= v2_in;
      ctx_a_r <= ctx_in;
      sum_r   <= sum_nxt;
      power_r <= FW'(pp_a_r >> FW);
      v2_r    <= v2_a_r;
      ctx_r   <= ctx_a_r;
    end
  end

endmodule
